// ===== hdl/mus_pkg.sv =====
`timescale 1ns / 1ps
package mus_pkg;
    localparam int VERTEX_DEPTH  = 4096;
    localparam int MAX_TRIANGLES = 65536;
    localparam int FRACTION_BITS = 16;

    localparam int IDX_W   = $clog2(VERTEX_DEPTH);
    localparam int COORD_W = 32;
    localparam int SQ_W    = 66;                      // sum of three 64-bit squares
    localparam int NUM_W   = SQ_W + 2 * FRACTION_BITS; // shifted dividend
    localparam int TALLY_W = $clog2(MAX_TRIANGLES + 1);
    localparam int CNT_W   = $clog2(NUM_W + 1);

    typedef logic [COORD_W-1:0] t_coord;
    typedef t_coord t_vertex [5];

    // one classified triangle request handed from front to back
    typedef struct packed {
        logic [SQ_W-1:0] p1;
        logic [SQ_W-1:0] p2;
        logic [SQ_W-1:0] u1;
        logic [SQ_W-1:0] u2;
        logic            last;
    } t_tri;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;
endpackage

// ===== hdl/mus_front.sv =====
`timescale 1ns / 1ps
module mus_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [11:0]           i_vertex_index,
    input  logic [31:0]           i_pos_x,
    input  logic [31:0]           i_pos_y,
    input  logic [31:0]           i_pos_z,
    input  logic [31:0]           i_tex_u,
    input  logic [31:0]           i_tex_v,
    input  logic [11:0]           i_corner_a,
    input  logic [11:0]           i_corner_b,
    input  logic [11:0]           i_corner_c,
    input  logic                  i_last_triangle,
    input  mus_pkg::t_q_stat      i_q_stat,
    output logic                  o_push,
    output mus_pkg::t_tri         o_tri
);
    import mus_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_RA, F_RB, F_RC, F_LC, F_MUL, F_PUSH} t_fstate;

    t_fstate                 r_state;
    logic [5*COORD_W-1:0]    r_mem [VERTEX_DEPTH];
    logic [5*COORD_W-1:0]    r_rd;
    logic [IDX_W-1:0]        w_rd_addr;
    logic [IDX_W-1:0]        r_ca, r_cb, r_cc;
    logic                    r_last;
    t_vertex                 r_va, r_vb, r_vc;
    logic [3:0]              r_cnt;
    logic [3:0]              r_pidx;
    logic [63:0]             r_prod;
    logic [SQ_W-1:0]         r_p1, r_p2, r_u1, r_u2;
    logic [2:0]              w_j;
    logic [COORD_W:0]        w_diff;
    logic [COORD_W:0]        w_mag;
    t_coord                  w_other;
    logic                    w_acc;

    assign o_in_ready = (r_state == F_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign o_push     = (r_state == F_PUSH) && !i_q_stat.full;
    assign o_tri      = '{p1: r_p1, p2: r_p2, u1: r_u1, u2: r_u2, last: r_last};

    always_comb begin
        case (r_state)
            F_RB:    w_rd_addr = r_cb;
            F_RC:    w_rd_addr = r_cc;
            default: w_rd_addr = r_ca;
        endcase
    end

    // one coordinate difference per cycle: b-a for steps 0..4, c-a for 5..9
    always_comb begin
        w_j     = (r_cnt < 4'd5) ? r_cnt[2:0] : 3'(r_cnt - 4'd5);
        if (w_j > 3'd4) w_j = 3'd0;
        w_other = (r_cnt < 4'd5) ? r_vb[w_j] : r_vc[w_j];
        w_diff  = {w_other[COORD_W-1], w_other} - {r_va[w_j][COORD_W-1], r_va[w_j]};
        w_mag   = w_diff[COORD_W] ? (~w_diff + 1'b1) : w_diff;
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !i_func)
            r_mem[i_vertex_index[IDX_W-1:0]] <= {i_tex_v, i_tex_u, i_pos_z, i_pos_y, i_pos_x};
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_acc && i_func) begin
                        r_ca    <= i_corner_a[IDX_W-1:0];
                        r_cb    <= i_corner_b[IDX_W-1:0];
                        r_cc    <= i_corner_c[IDX_W-1:0];
                        r_last  <= i_last_triangle;
                        r_state <= F_RA;
                    end
                end
                F_RA: r_state <= F_RB;
                F_RB: begin
                    for (int k = 0; k < 5; k++) r_va[k] <= r_rd[k*COORD_W +: COORD_W];
                    r_state <= F_RC;
                end
                F_RC: begin
                    for (int k = 0; k < 5; k++) r_vb[k] <= r_rd[k*COORD_W +: COORD_W];
                    r_state <= F_LC;
                end
                F_LC: begin
                    for (int k = 0; k < 5; k++) r_vc[k] <= r_rd[k*COORD_W +: COORD_W];
                    r_p1    <= '0;
                    r_p2    <= '0;
                    r_u1    <= '0;
                    r_u2    <= '0;
                    r_cnt   <= '0;
                    r_state <= F_MUL;
                end
                F_MUL: begin
                    // register the square of this difference, accumulate the previous square
                    if (r_cnt < 4'd10) begin
                        r_prod <= 64'(w_mag[COORD_W-1:0]) * 64'(w_mag[COORD_W-1:0]);
                        r_pidx <= r_cnt;
                    end
                    if (r_cnt != 4'd0) begin
                        if (r_pidx < 4'd3)       r_p1 <= r_p1 + SQ_W'(r_prod);
                        else if (r_pidx < 4'd5)  r_u1 <= r_u1 + SQ_W'(r_prod);
                        else if (r_pidx < 4'd8)  r_p2 <= r_p2 + SQ_W'(r_prod);
                        else                     r_u2 <= r_u2 + SQ_W'(r_prod);
                    end
                    if (r_cnt == 4'd10) r_state <= F_PUSH;
                    else                r_cnt   <= r_cnt + 4'd1;
                end
                F_PUSH: begin
                    if (!i_q_stat.full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/mus_fifo.sv =====
`timescale 1ns / 1ps
module mus_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mus_pkg::t_tri     i_data,
    input  logic              i_pop,
    output mus_pkg::t_tri     o_data,
    output mus_pkg::t_q_stat  o_stat
);
    import mus_pkg::*;

    t_tri       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;

    assign o_data       = r_slot[r_rp];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.valid = (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

// ===== hdl/mus_back.sv =====
`timescale 1ns / 1ps
module mus_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_min_len,
    input  mus_pkg::t_q_stat  i_q_stat,
    input  mus_pkg::t_tri     i_tri,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [31:0]       o_rms_stretch,
    output logic [31:0]       o_max_stretch
);
    import mus_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_DIV, B_SQRT, B_TALLY, B_OUT} t_bstate;

    t_bstate              r_state;
    t_tri                 r_tri;
    logic                 r_edge;
    logic                 r_final;
    logic [63:0]          r_sum;
    logic [31:0]          r_peak;
    logic [TALLY_W-1:0]   r_tally;
    logic [NUM_W-1:0]     r_num, r_quo;
    logic [SQ_W-1:0]      r_den, r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic [63:0]          r_sq;     // saturated squared-ratio term of current edge
    logic [63:0]          r_sn, r_sr, r_sb;
    logic [31:0]          w_thr;
    logic [SQ_W:0]        w_rem_sh;
    logic                 w_ge;
    logic [64:0]          w_t;
    logic                 w_sq_ge;
    logic [64:0]          w_sum_add;
    logic [63:0]          w_sum_sat;

    assign o_pop    = (r_state == B_IDLE) && i_q_stat.valid;
    assign w_thr    = 32'(i_min_len) * 32'(i_min_len);
    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_t      = {1'b0, r_sr} + {1'b0, r_sb};
    assign w_sq_ge  = {1'b0, r_sn} >= w_t;
    assign w_sum_add = {1'b0, r_sum} + {1'b0, r_sq};
    assign w_sum_sat = w_sum_add[64] ? '1 : w_sum_add[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_sum       <= '0;
            r_peak      <= '0;
            r_tally     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (i_q_stat.valid) begin
                        r_tri     <= i_tri;
                        r_edge    <= 1'b0;
                        r_final   <= 1'b0;
                        r_num     <= NUM_W'(i_tri.u1) << (2 * FRACTION_BITS);
                        r_den     <= i_tri.p1;
                        r_rem     <= '0;
                        r_cnt     <= '0;
                        if ((i_tri.p1 > SQ_W'(w_thr)) && (i_tri.p2 > SQ_W'(w_thr)))
                            r_state <= B_DIV;
                        else
                            r_state <= B_TALLY;
                    end
                end
                B_DIV: begin
                    // restoring division, one quotient bit a cycle
                    r_rem <= w_ge ? SQ_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[SQ_W-1:0];
                    r_quo <= {r_quo[NUM_W-2:0], w_ge};
                    r_num <= r_num << 1;
                    if (r_cnt == CNT_W'(NUM_W - 1)) begin
                        r_state <= B_SQRT;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                B_SQRT: begin
                    if (r_cnt == '0) begin
                        // quotient now complete: saturate and seed the root
                        r_sn  <= (|r_quo[NUM_W-1:64]) ? '1 : r_quo[63:0];
                        r_sq  <= (|r_quo[NUM_W-1:64+FRACTION_BITS]) ? '1 :
                                 r_quo[64+FRACTION_BITS-1:FRACTION_BITS];
                        r_sr  <= '0;
                        r_sb  <= 64'h4000_0000_0000_0000;
                        r_cnt <= r_cnt + 1'b1;
                    end else if (r_sb != '0) begin
                        if (w_sq_ge) begin
                            r_sn <= r_sn - w_t[63:0];
                            r_sr <= (r_sr >> 1) + r_sb;
                        end else begin
                            r_sr <= r_sr >> 1;
                        end
                        r_sb <= r_sb >> 2;
                    end else if (r_final) begin
                        o_rms_stretch <= r_sr[31:0];
                        o_max_stretch <= r_peak;
                        o_out_valid   <= 1'b1;
                        r_sum         <= '0;
                        r_peak        <= '0;
                        r_tally       <= '0;
                        r_state       <= B_OUT;
                    end else begin
                        r_sum <= w_sum_sat;
                        if (r_sr[31:0] > r_peak) r_peak <= r_sr[31:0];
                        if (!r_edge) begin
                            r_edge  <= 1'b1;
                            r_num   <= NUM_W'(r_tri.u2) << (2 * FRACTION_BITS);
                            r_den   <= r_tri.p2;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= B_DIV;
                        end else begin
                            r_state <= B_TALLY;
                        end
                    end
                end
                B_TALLY: begin
                    if (r_tally < TALLY_W'(MAX_TRIANGLES)) r_tally <= r_tally + 1'b1;
                    if (r_tri.last) begin
                        r_final <= 1'b1;
                        r_num   <= NUM_W'(r_sum) << FRACTION_BITS;
                        r_den   <= (r_tally < TALLY_W'(MAX_TRIANGLES)) ?
                                   SQ_W'(r_tally + 1'b1) : SQ_W'(r_tally);
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= B_DIV;
                    end else begin
                        r_state <= B_IDLE;
                    end
                end
                B_OUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/mesh_uv_stretch_metric_unit.sv =====
`timescale 1ns / 1ps
// Texture stretch metric for a triangle mesh. Vertex requests (func 0) are
// stored in the vertex memory. A triangle request holds the input in the front
// through the accept, three reads from the vertex memory, ten squarings on
// one 32x32 multiplier plus one to drain it, and the push, which waits while
// the queue is full; then, in the back, two bit-serial divisions plus two square
// roots if both edges exceed min_edge_length, and a further division and root
// on the last triangle. A two-entry queue between front and back lets vertex
// writes and triangle fetches continue while the back works or while a result
// waits to be taken.
module mesh_uv_stretch_metric_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_min_edge_length,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [11:0] i_vertex_index,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_tex_u,
    input  logic [31:0] i_tex_v,
    input  logic [11:0] i_corner_a,
    input  logic [11:0] i_corner_b,
    input  logic [11:0] i_corner_c,
    input  logic        i_last_triangle,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_rms_stretch,
    output logic [31:0] o_max_stretch
);
    import mus_pkg::*;

    logic        r_min_len;
    logic [15:0] r_min_edge;
    logic        w_push, w_pop;
    t_tri        w_tri_in, w_tri_out;
    t_q_stat     w_q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_edge <= 16'd1;
            r_min_len  <= 1'b0;
        end else if (i_cfg_valid) begin
            r_min_edge <= i_cfg_min_edge_length;
            r_min_len  <= 1'b1;
        end
    end

    mus_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_func(i_func), .i_vertex_index(i_vertex_index),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_tex_u(i_tex_u), .i_tex_v(i_tex_v),
        .i_corner_a(i_corner_a), .i_corner_b(i_corner_b), .i_corner_c(i_corner_c),
        .i_last_triangle(i_last_triangle),
        .i_q_stat(w_q_stat), .o_push(w_push), .o_tri(w_tri_in)
    );

    mus_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_data(w_tri_in),
        .i_pop(w_pop), .o_data(w_tri_out), .o_stat(w_q_stat)
    );

    mus_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_min_len(r_min_edge),
        .i_q_stat(w_q_stat), .i_tri(w_tri_out), .o_pop(w_pop),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_rms_stretch(o_rms_stretch), .o_max_stretch(o_max_stretch)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_stat.valid)
        else $error("queue read while empty");

    a_cfg_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> r_min_len && (r_min_edge == $past(i_cfg_min_edge_length)))
        else $error("threshold write lost");
endmodule

// ===== tb/sv/mesh_uv_stretch_metric_unit_test.sv =====
`timescale 1ns / 1ps
module mesh_uv_stretch_metric_unit_test;
    import mus_pkg::*;

    localparam logic FUNC_VERTEX   = 1'b0;
    localparam logic FUNC_TRIANGLE = 1'b1;
    localparam int   SETTLE_CYCLES = 2000;

    typedef struct {
        logic        func;
        logic [11:0] vidx;
        logic [31:0] px, py, pz, tu, tv;
        logic [11:0] ca, cb, cc;
        logic        last;
    } t_req;

    typedef struct {
        logic [31:0] rms;
        logic [31:0] peak;
    } t_stretch;

    typedef struct {
        t_req        req;
        bit          typed;
        t_stretch    want;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [15:0] i_cfg_min_edge_length = '0;
    logic        i_in_valid = 0;
    logic        i_func = 0;
    logic [11:0] i_vertex_index = '0;
    logic [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0, i_tex_u = '0, i_tex_v = '0;
    logic [11:0] i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;
    logic        i_last_triangle = 0;
    logic        i_out_ready = 0;
    logic        o_cfg_ready, o_in_ready, o_out_valid;
    logic [31:0] o_rms_stretch, o_max_stretch;

    mesh_uv_stretch_metric_unit DUT (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // predictor state
    logic [31:0]  vert_mirror [VERTEX_DEPTH][5];
    bit           vert_written [VERTEX_DEPTH];
    logic [63:0]  sq_sum;
    logic [31:0]  peak_ratio;
    int unsigned  tri_count;
    logic [15:0]  edge_floor;

    t_stretch     stretch_expect_q [$];
    t_row         rows [$];
    int           errors = 0;
    int           tx_idle = 0;
    int           rx_idle = 0;
    int           written_list [$];

    always @(posedge i_clk) i_out_ready <= ($urandom_range(99) >= rx_idle);

    task automatic stretch_mismatch(input string what, input logic [31:0] got, want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (stretch_expect_q.size() == 0) begin
                stretch_mismatch("unexpected result rms", o_rms_stretch, 'x);
            end else begin
                t_stretch w;
                w = stretch_expect_q.pop_front();
                if (o_rms_stretch !== w.rms) stretch_mismatch("rms_stretch", o_rms_stretch, w.rms);
                if (o_max_stretch !== w.peak) stretch_mismatch("max_stretch", o_max_stretch, w.peak);
            end
        end
    end

    function automatic logic [63:0] div_sat(input logic [127:0] n, input logic [127:0] d);
        logic [127:0] q;
        if (d == 0) return '1;
        q = n / d;
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [127:0] r;
        logic [127:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= n) r = t;
        end
        return r[63:0];
    endfunction

    function automatic logic [127:0] sq_delta(input logic [31:0] a, input logic [31:0] b);
        logic signed [33:0] d;
        logic [127:0] m;
        d = $signed({a[31], a[31], a}) - $signed({b[31], b[31], b});
        m = (d < 0) ? 128'(-d) : 128'(d);
        return m * m;
    endfunction

    task automatic predict_stretch(input t_req r, output bit fired, output t_stretch res);
        logic [31:0]  a [5], b [5], c [5];
        logic [127:0] p1, p2, u1, u2, thr;
        logic [63:0]  s1, s2, r1, r2, add, rt;
        fired = 0;
        res = '{default: '0};
        if (r.func == FUNC_VERTEX) begin
            vert_mirror[r.vidx] = '{r.px, r.py, r.pz, r.tu, r.tv};
            return;
        end
        a = vert_mirror[r.ca];
        b = vert_mirror[r.cb];
        c = vert_mirror[r.cc];
        p1 = sq_delta(b[0], a[0]) + sq_delta(b[1], a[1]) + sq_delta(b[2], a[2]);
        p2 = sq_delta(c[0], a[0]) + sq_delta(c[1], a[1]) + sq_delta(c[2], a[2]);
        u1 = sq_delta(b[3], a[3]) + sq_delta(b[4], a[4]);
        u2 = sq_delta(c[3], a[3]) + sq_delta(c[4], a[4]);
        thr = 128'(edge_floor) * 128'(edge_floor);
        if (p1 > thr && p2 > thr) begin
            s1 = div_sat(u1 << FRACTION_BITS, p1);
            s2 = div_sat(u2 << FRACTION_BITS, p2);
            r1 = root64(div_sat(u1 << (2 * FRACTION_BITS), p1));
            r2 = root64(div_sat(u2 << (2 * FRACTION_BITS), p2));
            add = s1 + s2;
            if (add < s1) add = '1;
            sq_sum = (sq_sum + add < sq_sum) ? '1 : sq_sum + add;
            if (r1 > peak_ratio) peak_ratio = r1[31:0];
            if (r2 > peak_ratio) peak_ratio = r2[31:0];
        end
        if (tri_count < MAX_TRIANGLES) tri_count++;
        if (!r.last) return;
        fired = 1;
        rt = root64(div_sat(128'(sq_sum) << FRACTION_BITS, 128'(tri_count)));
        res.rms  = rt[31:0];
        res.peak = peak_ratio;
        sq_sum = 0;
        peak_ratio = 0;
        tri_count = 0;
    endtask

    // caller sits just after a rising edge
    task automatic send_request(input t_req r, input bit typed, input t_stretch want);
        bit       fired;
        t_stretch got;
        while ($urandom_range(99) < tx_idle) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1;
        i_func          <= r.func;
        i_vertex_index  <= r.vidx;
        i_pos_x         <= r.px;
        i_pos_y         <= r.py;
        i_pos_z         <= r.pz;
        i_tex_u         <= r.tu;
        i_tex_v         <= r.tv;
        i_corner_a      <= r.ca;
        i_corner_b      <= r.cb;
        i_corner_c      <= r.cc;
        i_last_triangle <= r.last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_stretch(r, fired, got);
        if (r.func == FUNC_VERTEX && !vert_written[r.vidx]) begin
            vert_written[r.vidx] = 1;
            written_list.push_back(r.vidx);
        end
        if (fired) stretch_expect_q.push_back(typed ? want : got);
    endtask

    task automatic write_floor(input logic [15:0] v);
        i_in_valid <= 0;
        i_cfg_valid <= 1;
        i_cfg_min_edge_length <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        edge_floor = v;
        i_cfg_valid <= 0;
    endtask

    task automatic drain;
        i_in_valid <= 0;
        while (stretch_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_req vtx(input int idx, input logic [31:0] px, py, pz, tu, tv,
                                 input logic last = 0);
        t_req r;
        r = '{func: FUNC_VERTEX, vidx: 12'(idx), px: px, py: py, pz: pz, tu: tu, tv: tv,
              ca: 12'($urandom), cb: 12'($urandom), cc: 12'($urandom), last: last};
        return r;
    endfunction

    function automatic t_req tri3(input int a, b, c, input logic last);
        t_req r;
        r = '{func: FUNC_TRIANGLE, vidx: 12'($urandom), px: $urandom, py: $urandom,
              pz: $urandom, tu: $urandom, tv: $urandom,
              ca: 12'(a), cb: 12'(b), cc: 12'(c), last: last};
        return r;
    endfunction

    function automatic logic [31:0] rand_coord;
        logic [31:0] v;
        int sh;
        if ($urandom_range(3) == 0) return $urandom;
        sh = $urandom_range(4, 31);
        v = $urandom >> (32 - sh);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic int pick_corner;
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    task automatic add_row(input t_req r, input bit typed = 0,
                           input logic [31:0] rms = 0, input logic [31:0] peak = 0);
        t_row w;
        w.req = r;
        w.typed = typed;
        w.want = '{rms, peak};
        rows.push_back(w);
    endtask

    initial begin
        logic [15:0] floors [$];
        t_stretch    none;
        int          n_sent;
        none = '{default: '0};
        sq_sum = 0;
        peak_ratio = 0;
        tri_count = 0;
        edge_floor = 16'd1;

        add_row(vtx(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        add_row(vtx(4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF));
        // degenerate: one corner repeated, nothing added
        add_row(tri3(0, 0, 0, 1), 1, 32'h0, 32'h0);
        add_row(tri3(0, 4095, 4095, 1));
        add_row(vtx(1, 32'd2, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_row(vtx(2, 32'd0, 32'd2, 32'd0, 32'h8000_0000, 32'h8000_0000));
        add_row(vtx(3, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000));
        // tiny 3D edge, huge texture edge: both outputs saturate
        add_row(tri3(3, 1, 1, 1), 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(tri3(3, 1, 2, 0));
        add_row(tri3(3, 3, 3, 1));
        add_row(vtx(5, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 32'd0));
        add_row(vtx(6, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'h0002_0000));
        add_row(vtx(7, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        add_row(tri3(7, 5, 6, 1), 1, 32'h0002_3C6E, 32'h0002_0000);
        // edge length exactly at threshold does not count
        add_row(vtx(8, 32'd1, 32'd0, 32'd0, 32'h0001_0000, 32'd0));
        add_row(tri3(7, 8, 5, 1), 1, 32'h0, 32'h0);
        // last flag on a vertex request is ignored
        add_row(vtx(4095, 32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                    32'h5555_AAAA, 1));
        add_row(tri3(4095, 0, 1, 0));
        add_row(tri3(2, 4095, 5, 1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        tx_idle = 37;
        rx_idle = 72;
        foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);
        drain();

        floors = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 65534)), 16'd1,
                   16'($urandom_range(1, 4095))};
        n_sent = 0;
        foreach (floors[ph]) begin
            write_floor(floors[ph]);
            repeat (43) begin
                int t;
                if (n_sent >= 600) begin
                    tx_idle = 0;
                    rx_idle = 0;
                end else if (n_sent >= 300) begin
                    tx_idle = 72;
                    rx_idle = 37;
                end
                if ($urandom_range(9) == 0 || written_list.size() < 3) begin
                    // noise: stray vertex write or unterminated triangle
                    if ($urandom_range(1) || written_list.size() < 3)
                        send_request(vtx($urandom_range(4095), rand_coord(), rand_coord(),
                                         rand_coord(), rand_coord(), rand_coord(),
                                         1'($urandom_range(1))), 0, none);
                    else
                        send_request(tri3(pick_corner(), pick_corner(), pick_corner(), 0),
                                     0, none);
                    n_sent++;
                    continue;
                end
                repeat ($urandom_range(0, 4)) begin
                    send_request(vtx($urandom_range(1) ? $urandom_range(4095)
                                                       : $urandom_range(15),
                                     rand_coord(), rand_coord(), rand_coord(),
                                     rand_coord(), rand_coord()), 0, none);
                    n_sent++;
                end
                t = $urandom_range(1, 4);
                for (int k = 0; k < t; k++) begin
                    send_request(tri3(pick_corner(), pick_corner(), pick_corner(), k == t - 1),
                                 0, none);
                    n_sent++;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("PASS mesh_uv_stretch_metric_unit");
        else
            $display("FAIL mesh_uv_stretch_metric_unit");
        $finish;
    end

    initial begin
        #40ms;
        $display("FAIL mesh_uv_stretch_metric_unit");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/mus_pkg.sv
hdl/mus_front.sv
hdl/mus_fifo.sv
hdl/mus_back.sv
hdl/mesh_uv_stretch_metric_unit.sv
tb/sv/mesh_uv_stretch_metric_unit_test.sv
